// ----- src/ptc_pkg.sv -----
// Shared types, constants and helpers for the pressure/temperature compensation block.
package ptc_pkg;

    localparam int RAW_W      = 20;
    localparam int TEMP_W     = 32;
    localparam int WIDE_W     = 64;
    localparam int PA_W       = 23;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int SIDE_W     = 2 * TEMP_W;

    localparam logic [20:0] P_FULL_SCALE = 21'd1048576;
    localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
    localparam logic [63:0] NUM_SCALE    = 64'd3125;
    localparam logic signed [63:0] DIV_BIAS = 64'sd1 <<< 47;
    localparam logic [31:0] MILLI_PER_PA = 32'd1000;
    // 390625 / 100000 reduces to 125 / 32
    localparam logic [14:0] FRAC_MUL     = 15'd125;
    // ceil(2^36 / 125): exact floor division for 29-bit dividends
    localparam logic [29:0] RECIP_125    = 30'd549755814;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_COEFFS  = 2'd0,
        CFG_PRESS_LOW    = 2'd1,
        CFG_PRESS_HIGH   = 2'd2,
        CFG_PRESS_NINE   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
    } temp_cal_t;

    typedef struct packed {
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } press_cal_t;

    function automatic logic signed [63:0] sx16(input logic [15:0] v);
        return $signed({{48{v[15]}}, v});
    endfunction

    function automatic logic signed [31:0] sx16_32(input logic [15:0] v);
        return $signed({{16{v[15]}}, v});
    endfunction

endpackage

// ----- src/ptc_temp.sv -----
// Temperature stages: fine temperature and hundredths of a degree, 32-bit wrap.
module ptc_temp import ptc_pkg::*; #(
    parameter int SIDE_W = RAW_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [RAW_W-1:0]         raw_temperature,
    input  logic [SIDE_W-1:0]        side_in,
    input  temp_cal_t                cal,
    output logic                     out_valid,
    output logic signed [TEMP_W-1:0] fine,
    output logic signed [TEMP_W-1:0] centi,
    output logic [SIDE_W-1:0]        side_out
);

    localparam int NS = 5;

    logic [NS-1:0]       v_reg;
    logic [SIDE_W-1:0]   side_reg [NS];

    logic signed [31:0] d1_next, d2_next, d1_reg, d2_reg;
    logic signed [31:0] m1_next, sq_next, m1_reg, sq_reg;
    logic signed [31:0] v1_next, m3_next, v1_reg, m3_reg;
    logic signed [31:0] fine_next, fine4_reg, fine5_reg;
    logic signed [31:0] f5, centi_next, centi_reg;

    assign d1_next = $signed({15'd0, raw_temperature[19:3]}) - $signed({15'd0, cal.t1, 1'b0});
    assign d2_next = $signed({16'd0, raw_temperature[19:4]}) - $signed({16'd0, cal.t1});
    assign m1_next = d1_reg * sx16_32(cal.t2);
    assign sq_next = d2_reg * d2_reg;
    assign v1_next = m1_reg >>> 11;
    assign m3_next = (sq_reg >>> 12) * sx16_32(cal.t3);
    assign fine_next = v1_reg + (m3_reg >>> 14);
    assign f5 = (fine4_reg <<< 2) + fine4_reg + 32'sd128;
    assign centi_next = f5 >>> 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < NS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            m1_reg    <= m1_next;
            sq_reg    <= sq_next;
            v1_reg    <= v1_next;
            m3_reg    <= m3_next;
            fine4_reg <= fine_next;
            fine5_reg <= fine4_reg;
            centi_reg <= centi_next;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign fine      = fine5_reg;
    assign centi     = centi_reg;
    assign side_out  = side_reg[NS-1];

endmodule

// ----- src/ptc_press_pre.sv -----
// Pressure polynomial stages: builds the 64-bit dividend and divisor.
module ptc_press_pre import ptc_pkg::*; #(
    parameter int SIDE_W = ptc_pkg::SIDE_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [TEMP_W-1:0] fine,
    input  logic [RAW_W-1:0]         raw_pressure,
    input  logic [SIDE_W-1:0]        side_in,
    input  press_cal_t               cal,
    output logic                     out_valid,
    output logic signed [WIDE_W-1:0] num,
    output logic signed [WIDE_W-1:0] den,
    output logic [SIDE_W-1:0]        side_out
);

    localparam int NS = 6;

    logic [NS-1:0]     v_reg;
    logic [SIDE_W-1:0] side_reg [NS];
    logic [20:0]       pn_reg [NS-2];

    logic signed [32:0] a0_next, a0_reg;
    logic signed [65:0] aa_full;
    logic signed [63:0] aa_reg;
    logic signed [48:0] ap5_next, ap2_next, ap5_reg, ap2_reg, ap5_3_reg, ap2_3_reg;
    logic signed [63:0] b1_next, x_next, b1_reg, x_reg;
    logic signed [63:0] b_next, a2_next, b_reg, a2_reg;
    logic signed [63:0] s_next, n0_next, s_reg, n0_reg;
    logic [63:0]        prod_next, n1_next, prod_reg, n1_reg;

    assign a0_next  = {fine[31], fine} - FINE_OFFSET;
    assign aa_full  = a0_reg * a0_reg;
    assign ap5_next = a0_reg * $signed({{33{cal.p5[15]}}, cal.p5});
    assign ap2_next = a0_reg * $signed({{33{cal.p2[15]}}, cal.p2});
    assign b1_next  = aa_reg * sx16(cal.p6);
    assign x_next   = aa_reg * sx16(cal.p3);
    assign b_next   = b1_reg + ($signed({{15{ap5_3_reg[48]}}, ap5_3_reg}) <<< 17)
                    + (sx16(cal.p4) <<< 35);
    assign a2_next  = (x_reg >>> 8) + ($signed({{15{ap2_3_reg[48]}}, ap2_3_reg}) <<< 12);
    assign s_next   = a2_reg + DIV_BIAS;
    assign n0_next  = $signed({12'd0, pn_reg[3], 31'd0}) - b_reg;
    assign prod_next = s_reg * {48'd0, cal.p1};
    assign n1_next   = n0_reg * NUM_SCALE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < NS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            pn_reg[0] <= P_FULL_SCALE - {1'b0, raw_pressure};
            for (int k = 1; k < NS - 2; k++)
            begin
                pn_reg[k] <= pn_reg[k-1];
            end
            a0_reg    <= a0_next;
            aa_reg    <= aa_full[63:0];
            ap5_reg   <= ap5_next;
            ap2_reg   <= ap2_next;
            b1_reg    <= b1_next;
            x_reg     <= x_next;
            ap5_3_reg <= ap5_reg;
            ap2_3_reg <= ap2_reg;
            b_reg     <= b_next;
            a2_reg    <= a2_next;
            s_reg     <= s_next;
            n0_reg    <= n0_next;
            prod_reg  <= prod_next;
            n1_reg    <= n1_next;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign num       = $signed(n1_reg);
    assign den       = $signed(prod_reg) >>> 33;
    assign side_out  = side_reg[NS-1];

endmodule

// ----- src/ptc_div.sv -----
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
module ptc_div import ptc_pkg::*; #(
    parameter int SIDE_W = ptc_pkg::SIDE_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [WIDE_W-1:0] num,
    input  logic signed [WIDE_W-1:0] den,
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     out_valid,
    output logic signed [WIDE_W-1:0] quo,
    output logic                     den_zero,
    output logic [SIDE_W-1:0]        side_out
);

    localparam int NB = WIDE_W;

    logic [NB+1:0]       v_reg;
    logic [WIDE_W-1:0]   rem_reg  [NB+1];
    logic [WIDE_W-1:0]   quo_reg  [NB+1];
    logic [WIDE_W-1:0]   ud_reg   [NB+1];
    logic                flip_reg [NB+1];
    logic                zero_reg [NB+2];
    logic [SIDE_W-1:0]   side_reg [NB+2];
    logic [WIDE_W-1:0]   q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NB:0], in_valid};
        end
    end

    // entry: magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            quo_reg[0]  <= num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
            ud_reg[0]   <= den[WIDE_W-1] ? WIDE_W'(-den) : WIDE_W'(den);
            flip_reg[0] <= num[WIDE_W-1] ^ den[WIDE_W-1];
            zero_reg[0] <= (den == '0);
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= NB; k++)
    begin : g_step
        logic [WIDE_W:0] trial;

        assign trial = {rem_reg[k-1], quo_reg[k-1][WIDE_W-1]} - {1'b0, ud_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= trial[WIDE_W] ? {rem_reg[k-1][WIDE_W-2:0], quo_reg[k-1][WIDE_W-1]}
                                             : trial[WIDE_W-1:0];
                quo_reg[k]  <= {quo_reg[k-1][WIDE_W-2:0], ~trial[WIDE_W]};
                ud_reg[k]   <= ud_reg[k-1];
                flip_reg[k] <= flip_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // sign restore; most negative over minus one wraps naturally
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg          <= flip_reg[NB] ? -quo_reg[NB] : quo_reg[NB];
            zero_reg[NB+1] <= zero_reg[NB];
            side_reg[NB+1] <= side_reg[NB];
        end
    end

    assign out_valid = v_reg[NB+1];
    assign quo       = $signed(q_reg);
    assign den_zero  = zero_reg[NB+1];
    assign side_out  = side_reg[NB+1];

endmodule

// ----- src/ptc_press_post.sv -----
// Post-division stages: quadratic correction, scaling and conversion to whole pascals.
module ptc_press_post import ptc_pkg::*; #(
    parameter int SIDE_W = ptc_pkg::SIDE_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [WIDE_W-1:0] quo,
    input  logic                     den_zero,
    input  logic [SIDE_W-1:0]        side_in,
    input  press_cal_t               cal,
    output logic                     out_valid,
    output logic [PA_W-1:0]          pressure_pa,
    output logic                     pressure_valid,
    output logic [SIDE_W-1:0]        side_out
);

    localparam int NS = 7;

    logic [NS-1:0]      v_reg;
    logic [SIDE_W-1:0]  side_reg [NS];
    logic               zero_reg [NS];
    logic signed [63:0] p_reg [3];

    logic signed [63:0] ps_next, pp9_next, d0_next, ps_reg, pp9_reg, d0_reg, d0_3_reg;
    logic [63:0]        lo_next, lo_reg;
    logic [31:0]        cr_next, cr_reg;
    logic signed [63:0] c0_next, c0_reg, d0_4_reg;
    logic signed [63:0] t_next, t_reg;
    logic signed [63:0] p2_next, p2_reg;
    logic [14:0]        frac;
    logic [31:0]        milli_next, milli_reg;
    logic [58:0]        pq_next, pq_reg;

    assign ps_next  = quo >>> 13;
    assign pp9_next = sx16(cal.p9) * ps_next;
    assign d0_next  = sx16(cal.p8) * quo;
    assign lo_next  = {32'd0, pp9_reg[31:0]} * {32'd0, ps_reg[31:0]};
    assign cr_next  = pp9_reg[31:0] * ps_reg[63:32] + pp9_reg[63:32] * ps_reg[31:0];
    assign c0_next  = $signed(lo_reg + {cr_reg, 32'd0});
    assign t_next   = p_reg[2] + (c0_reg >>> 25) + (d0_4_reg >>> 19);
    assign p2_next  = (t_reg >>> 8) + (sx16(cal.p7) <<< 4);
    assign frac     = {7'd0, p2_reg[7:0]} * FRAC_MUL;
    assign milli_next = p2_reg[39:8] * MILLI_PER_PA + {22'd0, frac[14:5]};
    // milli / 1000 == (milli / 8) / 125
    assign pq_next  = {30'd0, milli_reg[31:3]} * {29'd0, RECIP_125};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            zero_reg[0] <= den_zero;
            for (int k = 1; k < NS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
            p_reg[0] <= quo;
            for (int k = 1; k < 3; k++)
            begin
                p_reg[k] <= p_reg[k-1];
            end
            ps_reg    <= ps_next;
            pp9_reg   <= pp9_next;
            d0_reg    <= d0_next;
            lo_reg    <= lo_next;
            cr_reg    <= cr_next;
            d0_3_reg  <= d0_reg;
            c0_reg    <= c0_next;
            d0_4_reg  <= d0_3_reg;
            t_reg     <= t_next;
            p2_reg    <= p2_next;
            milli_reg <= milli_next;
            pq_reg    <= pq_next;
        end
    end

    assign out_valid      = v_reg[NS-1];
    assign pressure_valid = ~zero_reg[NS-1];
    assign pressure_pa    = zero_reg[NS-1] ? '0 : pq_reg[58:36];
    assign side_out       = side_reg[NS-1];

endmodule

// ----- src/pressure_temperature_compensation_top.sv -----
// Top level: configuration registers, compensation pipeline and output skid stage.
//
// Barometric compensation pipeline. One input transaction carries a raw
// 20-bit temperature and a raw 20-bit pressure conversion; one output
// transaction returns temperature in hundredths of a degree, the fine
// temperature, pressure in pascals and a pressure-valid flag.
// Both channels are valid/ready; a transaction moves when both are high.
// Calibration is loaded through cfg_we/cfg_index/cfg_data, one register per
// write, and must only be changed while no transaction is in flight.
// Throughput: one transaction per cycle while in_ready is high. The pipeline
// runs through temperature, polynomial, signed divider (with its 64-stage
// quotient pipeline), post-scaling and output register stages.
// Reset clears all calibration registers to zero and empties the pipeline.
// When the receiver stalls, the output register holds its transaction and a
// skid register catches one more; in_ready drops only while the skid is full,
// which freezes every stage in place, so nothing is lost or repeated.
// A zero divisor gives pressure 0 with pressure_valid low.
module pressure_temperature_compensation_top import ptc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [RAW_W-1:0]         raw_temperature,
    input  logic [RAW_W-1:0]         raw_pressure,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [TEMP_W-1:0] temperature_centi,
    output logic signed [TEMP_W-1:0] fine_temperature,
    output logic [PA_W-1:0]          pressure_pa,
    output logic                     pressure_valid
);

    // calibration registers
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;

    temp_cal_t  tcal;
    press_cal_t pcal;

    // stage enable: the whole pipeline moves together
    logic en;

    logic                     t_valid;
    logic signed [TEMP_W-1:0] t_fine, t_centi;
    logic [RAW_W-1:0]         t_rp;

    logic                     pre_valid;
    logic signed [WIDE_W-1:0] pre_num, pre_den;
    logic [SIDE_W-1:0]        pre_side;

    logic                     div_valid;
    logic signed [WIDE_W-1:0] div_quo;
    logic                     div_zero;
    logic [SIDE_W-1:0]        div_side;

    logic                     post_valid;
    logic [PA_W-1:0]          post_pa;
    logic                     post_pv;
    logic [SIDE_W-1:0]        post_side;

    // output register plus one skid entry
    typedef struct packed {
        logic [TEMP_W-1:0] centi;
        logic [TEMP_W-1:0] fine;
        logic [PA_W-1:0]   pa;
        logic              pv;
    } result_t;

    result_t post_res, out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                CFG_PRESS_LOW:   press_low_reg   <= cfg_data;
                CFG_PRESS_HIGH:  press_high_reg  <= cfg_data;
                CFG_PRESS_NINE:  press_nine_reg  <= cfg_data[15:0];
                default:         press_nine_reg  <= press_nine_reg;
            endcase
        end
    end

    assign tcal.t1 = temp_coeffs_reg[15:0];
    assign tcal.t2 = temp_coeffs_reg[31:16];
    assign tcal.t3 = temp_coeffs_reg[47:32];
    assign pcal.p1 = press_low_reg[15:0];
    assign pcal.p2 = press_low_reg[31:16];
    assign pcal.p3 = press_low_reg[47:32];
    assign pcal.p4 = press_low_reg[63:48];
    assign pcal.p5 = press_high_reg[15:0];
    assign pcal.p6 = press_high_reg[31:16];
    assign pcal.p7 = press_high_reg[47:32];
    assign pcal.p8 = press_high_reg[63:48];
    assign pcal.p9 = press_nine_reg;

    assign en       = ~skid_valid_reg;
    assign in_ready = en;

    ptc_temp #(
        .SIDE_W (RAW_W)
    ) u_temp (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (in_valid),
        .raw_temperature (raw_temperature),
        .side_in         (raw_pressure),
        .cal             (tcal),
        .out_valid       (t_valid),
        .fine            (t_fine),
        .centi           (t_centi),
        .side_out        (t_rp)
    );

    ptc_press_pre #(
        .SIDE_W (SIDE_W)
    ) u_pre (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (t_valid),
        .fine         (t_fine),
        .raw_pressure (t_rp),
        .side_in      ({t_centi, t_fine}),
        .cal          (pcal),
        .out_valid    (pre_valid),
        .num          (pre_num),
        .den          (pre_den),
        .side_out     (pre_side)
    );

    ptc_div #(
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_valid),
        .num       (pre_num),
        .den       (pre_den),
        .side_in   (pre_side),
        .out_valid (div_valid),
        .quo       (div_quo),
        .den_zero  (div_zero),
        .side_out  (div_side)
    );

    ptc_press_post #(
        .SIDE_W (SIDE_W)
    ) u_post (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (div_valid),
        .quo            (div_quo),
        .den_zero       (div_zero),
        .side_in        (div_side),
        .cal            (pcal),
        .out_valid      (post_valid),
        .pressure_pa    (post_pa),
        .pressure_valid (post_pv),
        .side_out       (post_side)
    );

    assign post_res.centi = post_side[SIDE_W-1:TEMP_W];
    assign post_res.fine  = post_side[TEMP_W-1:0];
    assign post_res.pa    = post_pa;
    assign post_res.pv    = post_pv;

    assign take = out_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // pipeline frozen; drain the skid into the output register
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (post_valid)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (post_valid)
        begin
            if (out_valid_reg && !take)
            begin
                skid_reg <= post_res;
            end
            else
            begin
                out_reg <= post_res;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = $signed(out_reg.centi);
    assign fine_temperature  = $signed(out_reg.fine);
    assign pressure_pa       = out_reg.pa;
    assign pressure_valid    = out_reg.pv;

    // the skid only holds a transaction behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while the output is empty");

    // the skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without an output stall");

    // an invalid pressure always reads zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pressure_valid) |-> (pressure_pa == '0))
        else $error("invalid pressure is not zero");

endmodule

// ----- test/pressure_temperature_compensation_top_test.sv -----
// Self-checking testbench for the pressure/temperature compensation block.
`timescale 1ns / 1ps

// Directed and random raw conversion pairs are pushed through the block under
// several calibration sets. A local fixed-point predictor computes every result.
// Both channels idle at random, with one long receiver hold-off. Every output
// transaction is checked against the oldest predicted result.
module pressure_temperature_compensation_top_test;
    import ptc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 120;

    typedef struct {
        logic [RAW_W-1:0] rt;
        logic [RAW_W-1:0] rp;
    } sample_t;

    typedef struct {
        logic [31:0]     centi;
        logic [31:0]     fine;
        logic [PA_W-1:0] pa;
        logic            pvalid;
    } reading_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [RAW_W-1:0]      raw_temperature;
    logic [RAW_W-1:0]      raw_pressure;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [31:0]    temperature_centi;
    logic signed [31:0]    fine_temperature;
    logic [PA_W-1:0]       pressure_pa;
    logic                  pressure_valid;

    pressure_temperature_compensation_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
        .out_valid(out_valid), .out_ready(out_ready),
        .temperature_centi(temperature_centi), .fine_temperature(fine_temperature),
        .pressure_pa(pressure_pa), .pressure_valid(pressure_valid)
    );

    // local copy of the calibration registers
    logic [47:0] cal_temp;
    logic [63:0] cal_press_low;
    logic [63:0] cal_press_high;
    logic [15:0] cal_p9;

    sample_t  sample_queue[$];   // conversions waiting to be offered
    reading_t reading_queue[$];  // predicted readings, oldest first

    int  mismatches;
    bit  failed;
    bit  no_idle;         // suppresses random idling on both sides
    int  rx_hold_cycles;  // long receiver hold-off, counted down by the receiver
    bit  in_taken;        // input transaction seen at the last rising edge
    int  quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sext16_64(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Bit-accurate compensation: 32-bit wrap for temperature, 64-bit wrap for pressure.
    function automatic reading_t compensate(input sample_t s);
        reading_t    r;
        logic [31:0] t1, t2, t3, d1, d2, m, v1, v2, fine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] a, b, p, num, un, ud, q, ps, c, d, scaled;
        logic [31:0] milli;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        d1 = {15'd0, s.rt[19:3]} - (t1 << 1);
        m  = d1 * t2;
        v1 = $unsigned($signed(m) >>> 11);
        d2 = {16'd0, s.rt[19:4]} - t1;
        m  = d2 * d2;
        m  = $unsigned($signed(m) >>> 12);
        m  = m * t3;
        v2 = $unsigned($signed(m) >>> 14);
        fine = v1 + v2;
        m  = fine * 32'd5 + 32'd128;
        r.centi = $unsigned($signed(m) >>> 8);
        r.fine  = fine;

        p1 = {48'd0, cal_press_low[15:0]};
        p2 = sext16_64(cal_press_low[31:16]);
        p3 = sext16_64(cal_press_low[47:32]);
        p4 = sext16_64(cal_press_low[63:48]);
        p5 = sext16_64(cal_press_high[15:0]);
        p6 = sext16_64(cal_press_high[31:16]);
        p7 = sext16_64(cal_press_high[47:32]);
        p8 = sext16_64(cal_press_high[63:48]);
        p9 = sext16_64(cal_p9);

        a = {{32{fine[31]}}, fine} - 64'd128000;
        b = a * a * p6;
        b = b + ((a * p5) << 17);
        b = b + (p4 << 35);
        a = asr64(a * a * p3, 8) + ((a * p2) << 12);
        a = asr64(((64'd1 << 47) + a) * p1, 33);

        r.pa     = '0;
        r.pvalid = 1'b0;
        if (a != 64'd0)
        begin
            p   = 64'd1048576 - {44'd0, s.rp};
            num = ((p << 31) - b) * 64'd3125;
            // truncating signed divide; most negative / -1 wraps
            un  = num[63] ? (64'd0 - num) : num;
            ud  = a[63] ? (64'd0 - a) : a;
            q   = un / ud;
            p   = (num[63] != a[63]) ? (64'd0 - q) : q;
            ps  = asr64(p, 13);
            c   = asr64(p9 * ps * ps, 25);
            d   = asr64(p8 * p, 19);
            p   = asr64(p + c + d, 8) + (p7 << 4);
            scaled = asr64(p, 8) * 64'd1000 + ({56'd0, p[7:0]} * 64'd390625) / 64'd100000;
            milli  = scaled[31:0];
            m        = milli / 32'd1000;
            r.pa     = m[PA_W-1:0];
            r.pvalid = 1'b1;
        end
        return r;
    endfunction

    // One register per write, only while nothing is in flight.
    task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_TEMP_COEFFS: cal_temp       = value[47:0];
            CFG_PRESS_LOW:   cal_press_low  = value;
            CFG_PRESS_HIGH:  cal_press_high = value;
            CFG_PRESS_NINE:  cal_p9         = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_calibration(input logic [47:0] tc, input logic [63:0] lo,
                                    input logic [63:0] hi, input logic [15:0] nine);
        // upper bits of the data bus carry junk; the block must drop them
        write_reg(CFG_TEMP_COEFFS, {16'($urandom_range(0, 65535)), 48'd0} | {16'd0, tc});
        write_reg(CFG_PRESS_LOW, lo);
        write_reg(CFG_PRESS_HIGH, hi);
        write_reg(CFG_PRESS_NINE, {32'($urandom), 16'($urandom_range(0, 65535)), nine});
    endtask

    // Sender pause: nothing new until every predicted reading has come back.
    task automatic drain;
        while (sample_queue.size() != 0 || reading_queue.size() != 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_sample(input logic [RAW_W-1:0] rt, input logic [RAW_W-1:0] rp);
        sample_t s;
        s.rt = rt;
        s.rp = rp;
        sample_queue.push_back(s);
    endtask

    // Realistic conversions near room conditions, with the odd full-range pair.
    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                push_sample(20'($urandom_range(0, 1048575)), 20'($urandom_range(0, 1048575)));
            else
                push_sample(20'($urandom_range(480000, 560000)),
                            20'($urandom_range(250000, 600000)));
        end
    endtask

    function automatic logic [15:0] jitter(input int base, input int span);
        return 16'(base + $urandom_range(0, 2 * span) - span);
    endfunction

    // Typical calibration with random perturbation; mostly gives valid pressure.
    task automatic load_typical_random;
        load_calibration({jitter(-1000, 400), jitter(26435, 2000), jitter(27504, 2000)},
                         {jitter(2855, 500), jitter(3024, 500), jitter(-10685, 800),
                          jitter(36477, 3000)},
                         {jitter(-14600, 500), jitter(15500, 500), jitter(-7, 5),
                          jitter(140, 40)},
                         jitter(6000, 1000));
    endtask

    // Sampling block: records input transactions and checks output transactions.
    always @(posedge clk)
    begin
        reading_t want;
        reading_t got;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sample_t s;
                s.rt = raw_temperature;
                s.rp = raw_pressure;
                reading_queue.push_back(compensate(s));
                in_taken = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                got.centi  = temperature_centi;
                got.fine   = fine_temperature;
                got.pa     = pressure_pa;
                got.pvalid = pressure_valid;
                if (reading_queue.size() == 0)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output transaction: centi=%0d fine=%0d pa=%0d v=%0b",
                                 $signed(got.centi), $signed(got.fine), got.pa, got.pvalid);
                end
                else
                begin
                    want = reading_queue.pop_front();
                    if (got.centi !== want.centi || got.fine !== want.fine ||
                        got.pa !== want.pa || got.pvalid !== want.pvalid)
                    begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp centi=%0d fine=%0d pa=%0d v=%0b",
                                      " / got centi=%0d fine=%0d pa=%0d v=%0b"},
                                     $signed(want.centi), $signed(want.fine), want.pa,
                                     want.pvalid, $signed(got.centi), $signed(got.fine),
                                     got.pa, got.pvalid);
                    end
                end
            end
        end
    end

    // Driver: offers the next queued conversion pair, idling at random between transactions.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (sample_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 17))
            begin
                sample_t s;
                s = sample_queue.pop_front();
                in_valid        <= 1'b1;
                raw_temperature <= s.rt;
                raw_pressure    <= s.rp;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, plus the long hold-off when requested.
    always @(negedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            rx_hold_cycles--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= no_idle || ($urandom_range(0, 99) >= 17);
    end

    // Watchdog: cycles in which no transaction moves.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        raw_temperature = '0;
        raw_pressure = '0;
        out_ready = 1'b0;
        cal_temp = '0;
        cal_press_low = '0;
        cal_press_high = '0;
        cal_p9 = '0;
        mismatches = 0;
        failed = 1'b0;
        no_idle = 1'b0;
        rx_hold_cycles = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset calibration: all zero, so the divisor is zero
        push_sample(20'd0, 20'd0);
        push_sample(20'hFFFFF, 20'hFFFFF);
        push_sample(20'd519888, 20'd415148);
        drain();

        // typical calibration, field extremes
        load_calibration({16'hFC18, 16'd26435, 16'd27504},
                         {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                         {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
        push_sample(20'd0, 20'd0);
        push_sample(20'hFFFFF, 20'd0);
        push_sample(20'd0, 20'hFFFFF);
        push_sample(20'hFFFFF, 20'hFFFFF);
        push_sample(20'h55555, 20'hAAAAA);
        push_sample(20'hAAAAA, 20'h55555);
        push_sample(20'd519888, 20'd415148);
        push_sample(20'd524288, 20'd524288);
        drain();

        // all-ones coefficients: everything wraps
        load_calibration({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, 16'hFFFF);
        push_sample(20'd0, 20'd0);
        push_sample(20'hFFFFF, 20'hFFFFF);
        push_sample(20'd519888, 20'd415148);
        drain();

        // signed extremes of every coefficient
        load_calibration({16'h8000, 16'h7FFF, 16'hFFFF},
                         {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                         {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
        push_sample(20'd0, 20'hFFFFF);
        push_sample(20'hFFFFF, 20'd0);
        push_sample(20'd262144, 20'd786432);
        drain();

        // P1 zero with live temperature: zero divisor, temperature still computed
        load_calibration({16'hFC18, 16'd26435, 16'd27504},
                         {16'd2855, 16'd3024, 16'hD643, 16'd0},
                         {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
        push_sample(20'd519888, 20'd415148);
        push_sample(20'hFFFFF, 20'd1);
        drain();

        // random phases; one with the long receiver hold-off, one with no idling
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph % 3 == 2)
                load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                                 {$urandom, $urandom}, 16'($urandom));
            else
                load_typical_random();
            no_idle = (ph == 4);
            if (ph == 1)
                rx_hold_cycles = 400;
            push_random(200);
            drain();
        end
        no_idle = 1'b0;

        drain();
        if (!failed && reading_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
